// File: sv/tick_divided_temperature_averager_top_assert.svh
// Assertion macros shared by the averager modules.
`ifndef TICK_DIVIDED_TEMPERATURE_AVERAGER_TOP_ASSERT_SVH
`define TICK_DIVIDED_TEMPERATURE_AVERAGER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDTA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdta assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define TDTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdta assertion failed: next-cycle implication");

`endif

// File: sv/tdta_pkg.sv
package tdta_pkg;

   localparam int WINDOW_LEN = 10;
   localparam int ADC_W      = 10;
   localparam int TEMP_W     = 9;
   localparam int TICK_W     = 16;
   localparam int TEMP_MAX   = 499;
   localparam int RESET_TEMP = 60;
   localparam int DEG_SCALE  = 500;

   localparam int IDX_W      = $clog2(WINDOW_LEN);
   localparam int SUM_W      = $clog2(TEMP_MAX * WINDOW_LEN + 1);
   localparam int RESET_SUM  = RESET_TEMP * WINDOW_LEN;

   // Reciprocal multiply for sum / WINDOW_LEN, exact for every SUM_W-bit sum.
   localparam int DIV_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
   localparam int DIV_RECIP  = ((2 ** DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
   localparam int DIV_PROD_W = SUM_W + RECIP_W;

   localparam int DEG_PROD_W = ADC_W + $clog2(DEG_SCALE + 1);

   typedef struct packed {
      logic              wrapped;
      logic [TEMP_W-1:0] average;
   } win_result_type;

endpackage

// File: sv/tdta_req_if.sv
interface tdta_req_if import tdta_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;
   logic             heater_on;
   logic             setting_mode;

   modport source (output valid, adc_sample, heater_on, setting_mode, input ready);
   modport sink   (input valid, adc_sample, heater_on, setting_mode, output ready);
endinterface

// File: sv/tdta_rsp_if.sv
interface tdta_rsp_if import tdta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              sample_taken;
   logic [TEMP_W-1:0] average_temp;
   logic              window_wrapped;
   logic              heater_blink;
   logic              display_blink;

   modport source (output valid, sample_taken, average_temp, window_wrapped,
                   heater_blink, display_blink, input ready);
   modport sink   (input valid, sample_taken, average_temp, window_wrapped,
                   heater_blink, display_blink, output ready);
endinterface

// File: sv/tdta_window.sv
`include "tick_divided_temperature_averager_top_assert.svh"

module tdta_window import tdta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              sample_en,
   input  logic [TEMP_W-1:0] deg,
   output win_result_type    result
);

   logic [TEMP_W-1:0]     win_ff [WINDOW_LEN];
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic [TEMP_W-1:0]     held_ff;
   logic [TEMP_W-1:0]     avg_new;
   logic [DIV_PROD_W-1:0] quot_prod;
   logic                  last_slot;

   // Drop the oldest entry, add the new one, divide by reciprocal multiply.
   assign sum_in    = sum_ff - SUM_W'(win_ff[idx_ff]) + SUM_W'(deg);
   assign quot_prod = DIV_PROD_W'(sum_in) * DIV_PROD_W'(DIV_RECIP);
   assign avg_new   = quot_prod[DIV_SHIFT +: TEMP_W];
   assign last_slot = (idx_ff == IDX_W'(WINDOW_LEN - 1));
   assign idx_in    = last_slot ? '0 : idx_ff + IDX_W'(1);

   assign result.wrapped = sample_en && last_slot;
   assign result.average = sample_en ? avg_new : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= TEMP_W'(RESET_TEMP);
         end
         idx_ff  <= '0;
         sum_ff  <= SUM_W'(RESET_SUM);
         held_ff <= TEMP_W'(RESET_TEMP);
      end else if (sample_en) begin
         win_ff[idx_ff] <= deg;
         idx_ff         <= idx_in;
         sum_ff         <= sum_in;
         held_ff        <= avg_new;
      end
   end

   `TDTA_ASSERT_SAME(a_idx_in_range, clock, reset, 1'b1, idx_ff < IDX_W'(WINDOW_LEN))
   `TDTA_ASSERT_SAME(a_sum_bounded, clock, reset, 1'b1, sum_ff <= SUM_W'(TEMP_MAX * WINDOW_LEN))
   `TDTA_ASSERT_NEXT(a_wrap_restarts, clock, reset, result.wrapped, idx_ff == '0)

endmodule

// File: sv/tick_divided_temperature_averager_top.sv
// A word accepted into the input register is loaded into the result register when it
// advances, which needs the result register empty or being drained by rsp_chan.ready.
// Throughput: one word per cycle while rsp_chan.ready holds; both registers keep the flow.
// The window update, sum and reciprocal divide sit in the single compute stage.
// Reset (synchronous, active high): tick count 0, window entries 60, sum 600,
// held average 60, tick limit 0; both pipeline stages empty.
`include "tick_divided_temperature_averager_top_assert.svh"

module tick_divided_temperature_averager_top import tdta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tdta_req_if.sink          req_chan,
   tdta_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data
);

   // Configuration: tick limit, to be written only while idle; the block does not enforce this.
   logic [TICK_W-1:0] tick_limit_ff;

   // Input register stage.
   logic              in_valid_ff;
   logic [ADC_W-1:0]  in_sample_ff;
   logic              in_heater_ff;
   logic              in_setting_ff;

   // Tick counter.
   logic [TICK_W-1:0] tick_ff;
   logic [TICK_W-1:0] tick_inc;
   logic [TICK_W-1:0] tick_in;

   // Result register stage.
   logic              out_valid_ff;
   logic              out_taken_ff;
   logic [TEMP_W-1:0] out_avg_ff;
   logic              out_wrap_ff;
   logic              out_heater_ff;
   logic              out_display_ff;

   logic                  advance;
   logic                  sample_en;
   logic [DEG_PROD_W-1:0] deg_prod;
   logic [TEMP_W-1:0]     deg;
   win_result_type        win_res;

   // Advance the held word when the result register is empty or being drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Count the tick; sample once the incremented count passes the limit.
   assign tick_inc  = tick_ff + TICK_W'(1);
   assign sample_en = advance && (tick_inc > tick_limit_ff);
   assign tick_in   = (tick_inc > tick_limit_ff) ? '0 : tick_inc;

   // Degrees = floor(sample * 500 / 1024): constant multiply and shift.
   assign deg_prod = DEG_PROD_W'(in_sample_ff) * DEG_PROD_W'(DEG_SCALE);
   assign deg      = deg_prod[ADC_W +: TEMP_W];

   tdta_window u_window (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .deg       (deg),
      .result    (win_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_limit_ff <= '0;
      end else if (csr_wr_en) begin
         tick_limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (advance) begin
         tick_ff <= tick_in;
      end
   end

   // Input stage: hold the word until it moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_sample_ff  <= req_chan.adc_sample;
         in_heater_ff  <= req_chan.heater_on;
         in_setting_ff <= req_chan.setting_mode;
      end
   end

   // Result stage: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_taken_ff   <= sample_en;
         out_avg_ff     <= win_res.average;
         out_wrap_ff    <= win_res.wrapped;
         out_heater_ff  <= win_res.wrapped && in_heater_ff;
         out_display_ff <= win_res.wrapped && in_setting_ff;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.sample_taken   = out_taken_ff;
   assign rsp_chan.average_temp   = out_avg_ff;
   assign rsp_chan.window_wrapped = out_wrap_ff;
   assign rsp_chan.heater_blink   = out_heater_ff;
   assign rsp_chan.display_blink  = out_display_ff;

   `TDTA_ASSERT_SAME(a_wrap_needs_sample, clock, reset, out_valid_ff, !out_wrap_ff || out_taken_ff)
   `TDTA_ASSERT_SAME(a_blink_needs_wrap, clock, reset, out_valid_ff && (out_heater_ff || out_display_ff), out_wrap_ff)
   `TDTA_ASSERT_NEXT(a_sample_clears_tick, clock, reset, sample_en, tick_ff == '0)

endmodule
